FILE: design/u8d_pkg.sv
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int CodePointBitsDefault = 32;
   localparam int CodePointOutBits     = 32;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_START_CONT = 2'd1,
      ST_TOO_SHORT  = 2'd2,
      ST_BAD_CONT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [CodePointOutBits-1:0] code_point;
      status_type                  status;
      logic [2:0]                  bad_byte_index;
      logic [3:0]                  sequence_length;
   } result_type;

   localparam logic [7:0] LeadDataMask = 8'h7F;
   localparam logic [1:0] ContTag      = 2'b10;

   // count of leading one bits, 0..8
   function automatic logic [3:0] lead_ones(input logic [7:0] b);
      logic [3:0] n;
      logic       run;
      n   = 4'd0;
      run = 1'b1;
      for (int i = 7; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 4'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

endpackage

FILE: design/u8d_if.sv
`timescale 1ns / 1ps

interface u8d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface u8d_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_point;
   logic [1:0]  status;
   logic [2:0]  bad_byte_index;
   logic [3:0]  sequence_length;

   modport source (output valid, output code_point, output status,
                   output bad_byte_index, output sequence_length, input ready);
   modport sink (input valid, input code_point, input status,
                 input bad_byte_index, input sequence_length, output ready);
endinterface

FILE: design/u8d_decode.sv
`timescale 1ns / 1ps

module u8d_decode #(
   parameter int CODE_POINT_BITS = u8d_pkg::CodePointBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_message,
   output logic                 emit,
   output u8d_pkg::result_type  result
);
   import u8d_pkg::*;

   logic                       at_start_ff, at_start_in;
   logic                       given_ff, given_in;
   logic [3:0]                 exp_len_ff, exp_len_in;
   logic [3:0]                 seen_ff, seen_in;
   logic [CODE_POINT_BITS-1:0] acc_ff, acc_in;
   logic [2:0]                 bad_ff, bad_in;

   logic [3:0]                          n_ones;
   logic [7:0]                          lead_bits;
   logic [CODE_POINT_BITS+CodePointOutBits-1:0] acc_ext;

   assign n_ones    = lead_ones(data_byte);
   assign lead_bits = data_byte & (LeadDataMask >> n_ones);
   assign acc_ext   = {{CodePointOutBits{1'b0}}, acc_in};

   always_comb begin
      at_start_in = at_start_ff;
      given_in    = given_ff;
      exp_len_in  = exp_len_ff;
      seen_in     = seen_ff;
      acc_in      = acc_ff;
      bad_in      = bad_ff;
      emit        = 1'b0;
      result      = '0;
      if (go) begin
         if (at_start_ff) begin
            at_start_in = 1'b0;
            given_in    = 1'b0;
            bad_in      = 3'd0;
            seen_in     = 4'd1;
            if (n_ones == 4'd1) begin
               exp_len_in    = 4'd0;
               acc_in        = '0;
               emit          = 1'b1;
               given_in      = 1'b1;
               result.status = ST_START_CONT;
            end else begin
               exp_len_in = (n_ones == 4'd0) ? 4'd1 : n_ones;
               acc_in     = {{(CODE_POINT_BITS-8){1'b0}}, lead_bits};
               if (n_ones == 4'd0) begin
                  emit                   = 1'b1;
                  given_in               = 1'b1;
                  result.status          = ST_OK;
                  result.code_point      = acc_ext[CodePointOutBits-1:0];
                  result.sequence_length = 4'd1;
               end
            end
         end else if (!given_ff) begin
            if (data_byte[7:6] != ContTag && bad_ff == 3'd0) begin
               bad_in = seen_ff[2:0];
            end
            acc_in  = {acc_ff[CODE_POINT_BITS-7:0], data_byte[5:0]};
            seen_in = seen_ff + 4'd1;
            if (seen_in >= exp_len_ff) begin
               emit     = 1'b1;
               given_in = 1'b1;
               if (bad_in != 3'd0) begin
                  result.status         = ST_BAD_CONT;
                  result.bad_byte_index = bad_in;
               end else begin
                  result.status          = ST_OK;
                  result.code_point      = acc_ext[CodePointOutBits-1:0];
                  result.sequence_length = exp_len_ff;
               end
            end
         end
         // message end: report too short if no result was given, then await a new first byte
         if (end_of_message) begin
            if (!given_in) begin
               emit          = 1'b1;
               result        = '0;
               result.status = ST_TOO_SHORT;
            end
            at_start_in = 1'b1;
            given_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
         given_ff    <= 1'b0;
         exp_len_ff  <= 4'd0;
         seen_ff     <= 4'd0;
         acc_ff      <= '0;
         bad_ff      <= 3'd0;
      end else begin
         at_start_ff <= at_start_in;
         given_ff    <= given_in;
         exp_len_ff  <= exp_len_in;
         seen_ff     <= seen_in;
         acc_ff      <= acc_in;
         bad_ff      <= bad_in;
      end
   end

endmodule

FILE: design/u8d_queue.sv
`timescale 1ns / 1ps

module u8d_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u8d_pkg::result_type push_data,
   output logic                has_room,
   output logic                out_valid,
   input  logic                out_ready,
   output u8d_pkg::result_type out_data
);
   import u8d_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign has_room  = (count_ff != 2'd2);

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      case (count_ff)
         2'd0: begin
            if (push) head_in = push_data;
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               skid_in = push_data;
            end
         end
         2'd2: begin
            if (pop) head_in = skid_ff;
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: design/utf8_first_char_decoder_top.sv
`timescale 1ns / 1ps

// UTF-8 first character decoder. Bytes of a message come in on req, one item
// per byte, with end_of_message set on the last byte; for each message exactly
// one result item leaves on rsp: the code point of the first character with
// its sequence length, or an error status (starts with a continuation byte,
// message too short, or a bad continuation byte and its position). Bytes after
// the result are dropped until the end of the message. Throughput is one byte
// per cycle while req is not stalled: each byte passes through an input
// register, shift-and-OR decode logic that updates the per-message state,
// and a two-entry result queue. A byte leaves the input register for decode
// only while the queue has room, and its result is then pushed into the
// queue. req stalls only when two results are waiting on rsp and the input
// register holds a byte. The internal accumulator keeps CODE_POINT_BITS bits;
// the low 32 bits are reported.

module utf8_first_char_decoder_top #(
   parameter int CODE_POINT_BITS = u8d_pkg::CodePointBitsDefault
) (
   input logic     clock,
   input logic     reset,
   u8d_req_if.sink   req,
   u8d_rsp_if.source rsp
);
   import u8d_pkg::*;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eom_ff;

   logic       req_accept;
   logic       go;
   logic       q_room;
   logic       emit;
   result_type dec_result;
   result_type head;

   // byte moves into decode when the queue can take a possible result
   assign go         = in_valid_ff && q_room;
   assign req.ready  = !in_valid_ff || q_room;
   assign req_accept = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req.data_byte;
         in_eom_ff  <= req.end_of_message;
      end
   end

   // per-message decode state and result forming
   u8d_decode #(
      .CODE_POINT_BITS(CODE_POINT_BITS)
   ) u_decode (
      .clock          (clock),
      .reset          (reset),
      .go             (go),
      .data_byte      (in_byte_ff),
      .end_of_message (in_eom_ff),
      .emit           (emit),
      .result         (dec_result)
   );

   // result register plus skid entry
   u8d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_data (dec_result),
      .has_room  (q_room),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (head)
   );

   assign rsp.code_point      = head.code_point;
   assign rsp.status          = head.status;
   assign rsp.bad_byte_index  = head.bad_byte_index;
   assign rsp.sequence_length = head.sequence_length;

   // input only backs up when results are waiting
   a_stall_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> rsp.valid)
      else $error("req stalled with no result pending");

   // good results carry a length of one to eight
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status == ST_OK) |->
         (rsp.sequence_length != 4'd0 && rsp.sequence_length <= 4'd8))
      else $error("ok result with bad sequence length");

   // errors report no code point and no length
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.status != ST_OK) |->
         (rsp.code_point == 32'd0 && rsp.sequence_length == 4'd0))
      else $error("error result with nonzero payload");

   // byte index only with a bad continuation byte
   a_bad_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.status == ST_BAD_CONT) == (rsp.bad_byte_index != 3'd0)))
      else $error("bad byte index inconsistent with status");

endmodule
